FILE: design/pfr_pkg.sv
// Shared types and constants for the page frame replacement engine.
package pfr_pkg;

  localparam int FRAMES     = 64;
  localparam int FRAME_BITS = $clog2(FRAMES);
  localparam int COUNT_BITS = $clog2(FRAMES + 1);
  localparam int PAGE_BITS  = 20;
  localparam int TIME_BITS  = 32;
  localparam int WB_BITS    = 32;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 7;

  // item kinds
  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_MISS  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // replacement policies
  localparam logic POLICY_LRU   = 1'b0;
  localparam logic POLICY_CLOCK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAMES = 1'b1;

  typedef struct packed {
    logic [1:0]            kind;
    logic [FRAME_BITS-1:0] frame;
    logic [PAGE_BITS-1:0]  page_number;
    logic                  is_write;
    logic [TIME_BITS-1:0]  access_time;
  } pfr_req_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] victim_frame;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic                  evicted_valid;
    logic                  write_back;
    logic [WB_BITS-1:0]    write_back_total;
    logic [COUNT_BITS-1:0] dirty_count;
  } pfr_rsp_t;

  // write port of the last-use time store
  typedef struct packed {
    logic                  en;
    logic [FRAME_BITS-1:0] addr;
    logic [TIME_BITS-1:0]  data;
  } pfr_time_wr_t;

endpackage

FILE: design/pfr_time_store.sv
// Last-use time store: one write port, one registered read port, zero until written.
module pfr_time_store
  import pfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfr_time_wr_t          wr_i,
  input  logic [FRAME_BITS-1:0] rd_addr_i,
  output logic [TIME_BITS-1:0]  rd_time_o
);

  logic [TIME_BITS-1:0] mem_q [FRAMES];
  logic [FRAMES-1:0]    written_q;
  logic [TIME_BITS-1:0] rd_data_q;
  logic                 rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      rd_written_q <= written_q[rd_addr_i];
    end
  end

  // never-written entries read as empty
  assign rd_time_o = rd_written_q ? rd_data_q : '0;

endmodule

FILE: design/page_frame_replacement.sv
// Top level of the page frame replacement engine (LRU or second-chance clock).
//
// Usage:
//   Input: a transaction is taken on a rising edge with start high and busy low.
//   req_i carries kind (hit, miss, clear), frame, page number, write flag and time.
//   Every transaction gives exactly one result: result_valid_o is high for one
//   cycle with result_o; the receiver cannot hold it off, so nothing stalls.
//   Config: cfg_valid_i/cfg_ready_o write channel, index 0 is policy_mode and
//   index 1 is frames_in_use; ready is always high, write only while idle.
// Steps per kind (n = frames taking part):
//   hit, clear:    dirty-bit count over n frames, one frame per cycle
//   LRU miss:      time scan, page fetch, install, then dirty count
//   clock miss:    hand sweep, page fetch, install, then dirty count
//   One transaction at a time; busy is high until the result cycle, in which
//   the next transaction may already be taken. The LRU scan reads the time
//   store through its single read port.
// Reset: all frames empty, clean and unreferenced, hand on the last frame,
//   policy LRU, 64 frames, write-back total zero. Page store is not cleared.
module page_frame_replacement
  import pfr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  pfr_req_t                 req_i,
  output logic                     result_valid_o,
  output pfr_rsp_t                 result_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;  // LRU victim scan
  localparam logic [2:0] S_SWEEP   = 3'd2;  // clock hand sweep
  localparam logic [2:0] S_FETCH   = 3'd3;  // read victim's page
  localparam logic [2:0] S_INSTALL = 3'd4;
  localparam logic [2:0] S_COUNT   = 3'd5;  // dirty-bit count

  logic [2:0] state_q, state_d;

  // configuration
  logic                  policy_q;
  logic [COUNT_BITS-1:0] frames_q;
  logic [COUNT_BITS-1:0] n_now;
  logic [COUNT_BITS-1:0] n_q, n_d;

  // per-frame flags
  logic [FRAMES-1:0] valid_q, valid_d;
  logic [FRAMES-1:0] dirty_q, dirty_d;
  logic [FRAMES-1:0] ref_q, ref_d;

  logic [FRAME_BITS-1:0] hand_q, hand_d;
  logic [FRAME_BITS-1:0] h_q, h_d;
  logic [WB_BITS-1:0]    evictions_q, evictions_d;

  pfr_req_t req_q;
  logic     req_load;

  // scan datapath
  logic [COUNT_BITS-1:0] scan_idx_q, scan_idx_d;
  logic                  cmp_pend_q, cmp_pend_d;
  logic [FRAME_BITS-1:0] cmp_idx_q, cmp_idx_d;
  logic                  have_q, have_d;
  logic [FRAME_BITS-1:0] best_idx_q, best_idx_d;
  logic [TIME_BITS-1:0]  best_time_q, best_time_d;
  logic [TIME_BITS-1:0]  scan_time;
  logic                  take;

  logic [FRAME_BITS-1:0] victim_q, victim_d;
  logic [PAGE_BITS-1:0]  ev_page_q, ev_page_d;
  logic                  ev_valid_q, ev_valid_d;
  logic                  wb_q, wb_d;

  logic [FRAME_BITS-1:0] cnt_idx_q, cnt_idx_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic     res_valid_q, res_valid_d;
  pfr_rsp_t res_q;
  logic     res_load;

  // page store
  logic [PAGE_BITS-1:0] page_mem_q [FRAMES];
  logic [PAGE_BITS-1:0] page_rd_q;
  logic                 page_we;

  pfr_time_wr_t time_wr;
  logic         accept;

  function automatic logic [FRAME_BITS-1:0] advance(input logic [FRAME_BITS-1:0] h,
                                                    input logic [COUNT_BITS-1:0] n);
    logic [COUNT_BITS-1:0] nxt;
    nxt = COUNT_BITS'(h) + COUNT_BITS'(1);
    return (nxt >= n) ? '0 : nxt[FRAME_BITS-1:0];
  endfunction

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // frame count clamped to 1..FRAMES
  always_comb begin
    if (frames_q == '0) begin
      n_now = COUNT_BITS'(1);
    end else if (frames_q > COUNT_BITS'(FRAMES)) begin
      n_now = COUNT_BITS'(FRAMES);
    end else begin
      n_now = frames_q;
    end
  end

  pfr_time_store u_time (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (time_wr),
    .rd_addr_i (scan_idx_q[FRAME_BITS-1:0]),
    .rd_time_o (scan_time)
  );

  assign take = !have_q || (scan_time <= best_time_q);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    ref_d       = ref_q;
    hand_d      = hand_q;
    h_d         = h_q;
    evictions_d = evictions_q;
    scan_idx_d  = scan_idx_q;
    cmp_pend_d  = cmp_pend_q;
    cmp_idx_d   = cmp_idx_q;
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    victim_d    = victim_q;
    ev_page_d   = ev_page_q;
    ev_valid_d  = ev_valid_q;
    wb_d        = wb_q;
    cnt_idx_d   = cnt_idx_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_load    = 1'b0;
    req_load    = 1'b0;
    page_we     = 1'b0;
    time_wr     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_load   = 1'b1;
          n_d        = n_now;
          victim_d   = req_i.frame;
          ev_page_d  = '0;
          ev_valid_d = 1'b0;
          wb_d       = 1'b0;
          cnt_idx_d  = '0;
          cnt_d      = '0;
          state_d    = S_COUNT;
          priority case (req_i.kind)
            KIND_HIT: begin
              if (COUNT_BITS'(req_i.frame) < n_now) begin
                time_wr.en   = 1'b1;
                time_wr.addr = req_i.frame;
                time_wr.data = req_i.access_time;
                ref_d[req_i.frame] = 1'b1;
                if (req_i.is_write) begin
                  dirty_d[req_i.frame] = 1'b1;
                end
              end
            end
            KIND_MISS: begin
              if (policy_q == POLICY_LRU) begin
                scan_idx_d = '0;
                cmp_pend_d = 1'b0;
                have_d     = 1'b0;
                state_d    = S_SCAN;
              end else begin
                h_d     = advance(hand_q, n_now);
                state_d = S_SWEEP;
              end
            end
            KIND_CLEAR: begin
              for (int i = 0; i < FRAMES; i++) begin
                if (COUNT_BITS'(i) < n_now) begin
                  ref_d[i] = 1'b0;
                end
              end
            end
            default: begin
              // unused kind: no state change
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one frame's time per cycle, compare the one read last cycle
        if (scan_idx_q < n_q) begin
          cmp_pend_d = 1'b1;
          cmp_idx_d  = scan_idx_q[FRAME_BITS-1:0];
          scan_idx_d = scan_idx_q + COUNT_BITS'(1);
        end else begin
          cmp_pend_d = 1'b0;
        end
        if (cmp_pend_q) begin
          if (take) begin
            have_d      = 1'b1;
            best_idx_d  = cmp_idx_q;
            best_time_d = scan_time;
          end
          // first frame whose time reads zero wins at once
          if ((take && scan_time == '0) ||
              (COUNT_BITS'(cmp_idx_q) == n_q - COUNT_BITS'(1))) begin
            victim_d = take ? cmp_idx_q : best_idx_q;
            state_d  = S_FETCH;
          end
        end
      end

      S_SWEEP: begin
        if (ref_q[h_q]) begin
          ref_d[h_q] = 1'b0;
          h_d        = advance(h_q, n_q);
        end else begin
          victim_d = h_q;
          hand_d   = h_q;
          state_d  = S_FETCH;
        end
      end

      S_FETCH: begin
        state_d = S_INSTALL;
      end

      S_INSTALL: begin
        ev_valid_d = valid_q[victim_q];
        ev_page_d  = valid_q[victim_q] ? page_rd_q : '0;
        if (policy_q == POLICY_LRU) begin
          wb_d = dirty_q[victim_q];
          if (dirty_q[victim_q]) begin
            evictions_d = evictions_q + WB_BITS'(1);
          end
          dirty_d[victim_q] = req_q.is_write;
        end
        page_we           = 1'b1;
        valid_d[victim_q] = 1'b1;
        ref_d[victim_q]   = 1'b1;
        time_wr.en        = 1'b1;
        time_wr.addr      = victim_q;
        time_wr.data      = req_q.access_time;
        cnt_idx_d         = '0;
        cnt_d             = '0;
        state_d           = S_COUNT;
      end

      S_COUNT: begin
        cnt_d     = cnt_q + COUNT_BITS'(dirty_q[cnt_idx_q]);
        cnt_idx_d = cnt_idx_q + FRAME_BITS'(1);
        if (COUNT_BITS'(cnt_idx_q) == n_q - COUNT_BITS'(1)) begin
          res_valid_d = 1'b1;
          res_load    = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= POLICY_LRU;
      frames_q    <= COUNT_BITS'(FRAMES);
      n_q         <= COUNT_BITS'(FRAMES);
      valid_q     <= '0;
      dirty_q     <= '0;
      ref_q       <= '0;
      hand_q      <= FRAME_BITS'(FRAMES - 1);
      h_q         <= '0;
      evictions_q <= '0;
      scan_idx_q  <= '0;
      cmp_pend_q  <= 1'b0;
      have_q      <= 1'b0;
      cnt_idx_q   <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      ref_q       <= ref_d;
      hand_q      <= hand_d;
      h_q         <= h_d;
      evictions_q <= evictions_d;
      scan_idx_q  <= scan_idx_d;
      cmp_pend_q  <= cmp_pend_d;
      have_q      <= have_d;
      cnt_idx_q   <= cnt_idx_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_POLICY: policy_q <= cfg_data_i[0];
          CFG_FRAMES: frames_q <= cfg_data_i[COUNT_BITS-1:0];
          default:    ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_q <= req_i;
    end
    cmp_idx_q   <= cmp_idx_d;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
    victim_q    <= victim_d;
    ev_page_q   <= ev_page_d;
    ev_valid_q  <= ev_valid_d;
    wb_q        <= wb_d;
    if (res_load) begin
      res_q.victim_frame     <= victim_q;
      res_q.evicted_page     <= ev_page_q;
      res_q.evicted_valid    <= ev_valid_q;
      res_q.write_back       <= wb_q;
      res_q.write_back_total <= evictions_q;
      res_q.dirty_count      <= cnt_d;
    end
  end

  // page store: written on install, victim read registered in the fetch state
  always_ff @(posedge clk_i) begin
    if (page_we) begin
      page_mem_q[victim_q] <= req_q.page_number;
    end
    page_rd_q <= page_mem_q[victim_q];
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // result strobe only ever follows the final count step
  a_strobe_after_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_COUNT))
    else $error("result strobe without a finished count");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("transaction accepted but engine not busy");

  a_victim_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSTALL) |-> (COUNT_BITS'(victim_q) < n_q))
    else $error("victim outside frames in use");

  a_dirty_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.dirty_count <= n_q))
    else $error("dirty count exceeds frames in use");

  a_wb_lru_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.write_back) |->
      (policy_q == POLICY_LRU && req_q.kind == KIND_MISS))
    else $error("write-back outside an LRU miss");

endmodule
